### sv/swma_pkg.sv
// Shared types and constants of the sliding window median alert block.
// No dependencies; swma_channels, swma_scan, the top level and the testbench import this package.
`default_nettype none

package swma_pkg;

  localparam int SAMPLE_W = 8;   // input sample field
  localparam int CFG_W    = 11;  // window_length register
  localparam int TM_W     = 9;   // twice_median result field
  localparam int ACNT_W   = 32;  // alert_count result field

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DEC_RD,
    ST_DEC_WR,
    ST_INC_RD,
    ST_INC_WR,
    ST_OUT
  } swma_state_t;

  typedef struct packed {
    logic start;  // clear accumulator and found flags
    logic step;   // take one bin count
  } scan_ctrl_t;

endpackage

`default_nettype wire

### sv/swma_channels.sv
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on swma_pkg for the field widths.
`default_nettype none

interface swma_in_if
  import swma_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swma_out_if
  import swma_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [TM_W-1:0]   twice_median;
  logic              alert;
  logic [ACNT_W-1:0] alert_count;

  modport source (output valid, output twice_median, output alert, output alert_count,
                  input ready);
  modport sink   (input valid, input twice_median, input alert, input alert_count,
                  output ready);
endinterface

`default_nettype wire

### sv/swma_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module swma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/swma_scan.sv
// Cumulative rank scan: adds one bin count per step and records the first
// bins that reach the lower and upper middle ranks. Depends on swma_pkg.
`default_nettype none

module swma_scan
  import swma_pkg::*;
#(
  parameter int BIN_W = 8,
  parameter int CNT_W = 11
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire scan_ctrl_t       ctl,
  input  wire logic [BIN_W-1:0] bin,
  input  wire logic [CNT_W-1:0] count,
  input  wire logic [CNT_W-1:0] lower_rank,
  input  wire logic [CNT_W-1:0] upper_rank,
  output logic      [BIN_W:0]   sum
);

  logic [CNT_W-1:0] cum;
  logic [CNT_W-1:0] cum_next;
  logic [BIN_W-1:0] lower;
  logic [BIN_W-1:0] upper;
  logic             have_lower;
  logic             have_upper;

  assign cum_next = cum + count;
  assign sum      = {1'b0, lower} + {1'b0, upper};

  always_ff @(posedge clk) begin
    if (rst || ctl.start) begin
      cum        <= '0;
      lower      <= '0;
      upper      <= '0;
      have_lower <= 1'b0;
      have_upper <= 1'b0;
    end else if (ctl.step) begin
      cum <= cum_next;
      if (!have_lower && cum_next >= lower_rank) begin
        lower      <= bin;
        have_lower <= 1'b1;
      end
      if (!have_upper && cum_next >= upper_rank) begin
        upper      <= bin;
        have_upper <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### sv/sliding_window_median_alert.sv
// Top level of the sliding window median alert block: sequencer, histogram
// and history RAMs, rank scan unit. Depends on swma_pkg, swma_channels,
// swma_ram and swma_scan.
//
//   channel     | dir | handshake           | word
//   ------------+-----+---------------------+----------------------------------
//   sample_ch   | in  | valid/ready         | sample
//   result_ch   | out | valid/ready         | twice_median, alert, alert_count
//   cfg         | in  | cfg_wen, no wait    | cfg_wdata = window_length
//
// A word taken while the window is still filling gives no result. Once the
// window is full the scan reads every histogram bin through the one read
// port of the histogram RAM, then the oldest bin is decremented and the new
// bin incremented through the same port, and the output state hands the
// result to the output register. A finished result sits in the output
// register while the next word is accepted; a new result waits in the
// sequencer, with sample_ch.ready low, only while the previous one has not
// been taken. After reset and after every write of window_length a clearing
// pass zeroes every histogram bin, and sample_ch.ready stays low meanwhile.
`default_nettype none

module sliding_window_median_alert
  import swma_pkg::*;
#(
  parameter int NUM_BINS   = 256,
  parameter int WINDOW_MAX = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wen,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  swma_in_if.sink               sample_ch,
  swma_out_if.source            result_ch
);

  localparam int BIN_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int RING_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int HIST_W = (BIN_W < SAMPLE_W) ? BIN_W : SAMPLE_W;
  localparam int SAT_W  = (BIN_W > SAMPLE_W) ? BIN_W : SAMPLE_W;
  localparam int LEN_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

  swma_state_t        state;
  swma_state_t        state_next;
  logic [BIN_W-1:0]   bin_idx;
  logic [CNT_W-1:0]   len_eff;
  logic [CNT_W-1:0]   fill_count;
  logic [RING_W-1:0]  ring_pos;
  logic [ACNT_W-1:0]  alert_total;
  logic [BIN_W-1:0]   cur_sample;
  logic               window_full;
  logic               step_q;
  logic [BIN_W-1:0]   step_bin;
  logic               res_valid;
  logic [TM_W-1:0]    res_twice;
  logic               res_alert;
  logic [ACNT_W-1:0]  res_count;

  // histogram RAM
  logic               bin_we;
  logic [BIN_W-1:0]   bin_waddr;
  logic [CNT_W-1:0]   bin_wdata;
  logic [BIN_W-1:0]   bin_raddr;
  logic [CNT_W-1:0]   bin_rdata;

  // history ring RAM
  logic               hist_we;
  logic [HIST_W-1:0]  hist_rdata;

  scan_ctrl_t         scan_ctl;
  logic [BIN_W:0]     mid_sum;
  logic [CNT_W-1:0]   lower_rank;
  logic [CNT_W-1:0]   upper_rank;
  logic [CNT_W:0]     len_plus1;

  logic               in_accept;
  logic               out_free;
  logic [SAT_W-1:0]   sample_ext;
  logic [BIN_W-1:0]   sample_sat;
  logic [BIN_W-1:0]   oldest;
  logic [LEN_W-1:0]   cfg_ext;
  logic [CNT_W-1:0]   cfg_len;
  logic [CNT_W-1:0]   ring_inc;
  logic               alert_flag;

  assign sample_ch.ready = (state == ST_IDLE);
  assign in_accept       = sample_ch.valid && sample_ch.ready;
  assign out_free        = !res_valid || result_ch.ready;

  assign result_ch.valid        = res_valid;
  assign result_ch.twice_median = res_twice;
  assign result_ch.alert        = res_alert;
  assign result_ch.alert_count  = res_count;

  // Clamp the sample to the last bin when it lies above NUM_BINS - 1.
  assign sample_ext = SAT_W'(sample_ch.sample);
  assign sample_sat = (sample_ext > SAT_W'(NUM_BINS - 1)) ? LAST_BIN : BIN_W'(sample_ext);
  assign oldest     = BIN_W'(hist_rdata);

  // Zero length means one, anything above the ring depth means the full ring.
  assign cfg_ext = LEN_W'(cfg_wdata);
  assign cfg_len = (cfg_wdata == '0)                  ? CNT_W'(1) :
                   (cfg_ext > LEN_W'(WINDOW_MAX))     ? CNT_W'(WINDOW_MAX) :
                                                        CNT_W'(cfg_ext);

  // Middle ranks: (len+1)/2 and len/2+1.
  assign len_plus1  = {1'b0, len_eff} + 1'b1;
  assign lower_rank = CNT_W'(len_plus1 >> 1);
  assign upper_rank = (len_eff >> 1) + 1'b1;

  assign ring_inc   = CNT_W'(ring_pos) + 1'b1;
  assign alert_flag = ({1'b0, cur_sample} >= mid_sum);

  // Sequencer: next state and RAM port steering.
  always_comb begin
    state_next   = state;
    bin_we       = 1'b0;
    bin_waddr    = bin_idx;
    bin_wdata    = '0;
    bin_raddr    = bin_idx;
    hist_we      = 1'b0;
    scan_ctl     = '0;
    scan_ctl.step = step_q;
    case (state)
      ST_CLEAR: begin
        bin_we = 1'b1;
        if (bin_idx == LAST_BIN) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          scan_ctl.start = 1'b1;
          state_next = (fill_count < len_eff) ? ST_INC_RD : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (bin_idx == LAST_BIN) begin
          state_next = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        // last bin count lands in the scan unit this cycle
        state_next = ST_DEC_RD;
      end
      ST_DEC_RD: begin
        bin_raddr  = oldest;
        state_next = ST_DEC_WR;
      end
      ST_DEC_WR: begin
        // drop the oldest sample from its bin
        bin_waddr  = oldest;
        bin_wdata  = bin_rdata - 1'b1;
        bin_we     = (bin_rdata != '0);
        state_next = ST_INC_RD;
      end
      ST_INC_RD: begin
        bin_raddr  = cur_sample;
        state_next = ST_INC_WR;
      end
      ST_INC_WR: begin
        bin_waddr  = cur_sample;
        bin_wdata  = bin_rdata + 1'b1;
        bin_we     = 1'b1;
        hist_we    = 1'b1;
        state_next = window_full ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
    if (cfg_wen) begin
      state_next = ST_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Control and window bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_idx     <= '0;
      len_eff     <= CNT_W'(1);
      fill_count  <= '0;
      ring_pos    <= '0;
      alert_total <= '0;
      step_q      <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      step_q <= (state == ST_SCAN);

      if (state == ST_OUT && out_free) begin
        res_valid <= 1'b1;
      end else if (result_ch.ready) begin
        res_valid <= 1'b0;
      end

      if (cfg_wen) begin
        len_eff     <= cfg_len;
        fill_count  <= '0;
        ring_pos    <= '0;
        alert_total <= '0;
        bin_idx     <= '0;
      end else begin
        if ((state == ST_CLEAR || state == ST_SCAN) && bin_idx != LAST_BIN) begin
          bin_idx <= bin_idx + 1'b1;
        end else begin
          bin_idx <= '0;
        end

        if (state == ST_INC_WR) begin
          // advance the ring, wrap at the window length
          ring_pos <= (ring_inc >= len_eff) ? '0 : RING_W'(ring_inc);
          if (!window_full) begin
            fill_count <= fill_count + 1'b1;
          end
        end

        if (state == ST_OUT && out_free) begin
          if (alert_flag && alert_total != '1) begin
            alert_total <= alert_total + 1'b1;
          end
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    step_bin <= bin_idx;
    if (in_accept) begin
      cur_sample  <= sample_sat;
      window_full <= (fill_count >= len_eff);
    end
    if (state == ST_OUT && out_free) begin
      res_twice <= TM_W'(mid_sum);
      res_alert <= alert_flag;
      res_count <= (alert_flag && alert_total != '1) ? alert_total + 1'b1 : alert_total;
    end
  end

  swma_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (bin_we),
    .waddr (bin_waddr),
    .wdata (bin_wdata),
    .raddr (bin_raddr),
    .rdata (bin_rdata)
  );

  swma_ram #(
    .WIDTH (HIST_W),
    .DEPTH (WINDOW_MAX)
  ) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (ring_pos),
    .wdata (HIST_W'(cur_sample)),
    .raddr (ring_pos),
    .rdata (hist_rdata)
  );

  swma_scan #(
    .BIN_W (BIN_W),
    .CNT_W (CNT_W)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .ctl        (scan_ctl),
    .bin        (step_bin),
    .count      (bin_rdata),
    .lower_rank (lower_rank),
    .upper_rank (upper_rank),
    .sum        (mid_sum)
  );

  // A register write always restarts the clearing pass.
  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_wen |=> state == ST_CLEAR)
    else $error("config write did not start clearing pass");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= len_eff)
    else $error("fill count beyond window length");

  a_ring_bound: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(ring_pos) < len_eff)
    else $error("ring position beyond window length");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(res_valid) |-> $past(state) == ST_OUT)
    else $error("result loaded outside of output state");

  a_alert_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(cfg_wen) |-> alert_total >= $past(alert_total))
    else $error("alert count decreased without a register write");

endmodule

`default_nettype wire

### tb/sliding_window_median_alert_tb.sv
// Self-checking testbench for the sliding window median alert block.
// Drives sample words and window_length writes, predicts every result word.
// Depends on swma_pkg, swma_channels and the sliding_window_median_alert RTL.
`default_nettype none

module sliding_window_median_alert_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swma_pkg::*;

  localparam int NUM_BINS       = 256;
  localparam int WINDOW_MAX     = 1024;
  // Quiet time before a register write or the final verdict: one full scan
  // plus margin, and longer than a clearing pass.
  localparam int SETTLE_CYCLES  = NUM_BINS + 44;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 2500;
  // Results into the second random phase before the long hold-off starts.
  localparam int HOLD_AFTER     = 4;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_ITEMS   = 1475;
  localparam int NUM_ROWS       = 25;

  typedef struct packed {
    logic [TM_W-1:0]   twice_median;
    logic              alert;
    logic [ACNT_W-1:0] alert_count;
  } median_word_t;

  // One directed row: optional window_length write ahead of the sample, and
  // an expected word typed in by hand where it is obvious.
  typedef struct packed {
    logic               set_len;
    logic [CFG_W-1:0]   len;
    logic [SAMPLE_W-1:0] sample;
    logic               typed;
    median_word_t       want;
  } stim_row_t;

  // Window of length 1 after reset, then lengths 0 (taken as 1), 2, 3 and 4.
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{1'b0, 11'd0, 8'd0,   1'b0, '{9'd0,   1'b0, 32'd0}},
    '{1'b0, 11'd0, 8'd255, 1'b1, '{9'd0,   1'b1, 32'd1}},
    '{1'b0, 11'd0, 8'd0,   1'b1, '{9'd510, 1'b0, 32'd1}},
    '{1'b0, 11'd0, 8'd255, 1'b1, '{9'd0,   1'b1, 32'd2}},
    '{1'b1, 11'd0, 8'd7,   1'b0, '{9'd0,   1'b0, 32'd0}},
    '{1'b0, 11'd0, 8'd7,   1'b1, '{9'd14,  1'b0, 32'd0}},
    '{1'b1, 11'd2, 8'd10,  1'b0, '{9'd0,   1'b0, 32'd0}},
    '{1'b0, 11'd0, 8'd20,  1'b0, '{9'd0,   1'b0, 32'd0}},
    '{1'b0, 11'd0, 8'd5,   1'b1, '{9'd30,  1'b0, 32'd0}},
    '{1'b0, 11'd0, 8'd255, 1'b1, '{9'd25,  1'b1, 32'd1}},
    '{1'b0, 11'd0, 8'd0,   1'b0, '{9'd0,   1'b0, 32'd0}},
    '{1'b1, 11'd3, 8'd100, 1'b0, '{9'd0,   1'b0, 32'd0}},
    '{1'b0, 11'd0, 8'd200, 1'b0, '{9'd0,   1'b0, 32'd0}},
    '{1'b0, 11'd0, 8'd50,  1'b0, '{9'd0,   1'b0, 32'd0}},
    '{1'b0, 11'd0, 8'd150, 1'b1, '{9'd200, 1'b0, 32'd0}},
    '{1'b0, 11'd0, 8'd200, 1'b0, '{9'd0,   1'b0, 32'd0}},
    '{1'b0, 11'd0, 8'd255, 1'b0, '{9'd0,   1'b0, 32'd0}},
    '{1'b0, 11'd0, 8'd0,   1'b0, '{9'd0,   1'b0, 32'd0}},
    '{1'b1, 11'd4, 8'd3,   1'b0, '{9'd0,   1'b0, 32'd0}},
    '{1'b0, 11'd0, 8'd9,   1'b0, '{9'd0,   1'b0, 32'd0}},
    '{1'b0, 11'd0, 8'd1,   1'b0, '{9'd0,   1'b0, 32'd0}},
    '{1'b0, 11'd0, 8'd6,   1'b0, '{9'd0,   1'b0, 32'd0}},
    '{1'b0, 11'd0, 8'd255, 1'b1, '{9'd9,   1'b1, 32'd1}},
    '{1'b0, 11'd0, 8'd12,  1'b0, '{9'd0,   1'b0, 32'd0}},
    '{1'b0, 11'd0, 8'd2,   1'b0, '{9'd0,   1'b0, 32'd0}}
  };

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_wen;
  logic [CFG_W-1:0] cfg_wdata;

  swma_in_if  sample_ch ();
  swma_out_if result_ch ();

  sliding_window_median_alert #(
    .NUM_BINS   (NUM_BINS),
    .WINDOW_MAX (WINDOW_MAX)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .sample_ch (sample_ch),
    .result_ch (result_ch)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // Median predictor: private copy of window_length, histogram, sample ring,
  // fill level, ring pointer and alert total.
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0]    win_len_reg;
  logic [10:0]         hist_bins [NUM_BINS];
  logic [SAMPLE_W-1:0] hist_ring [WINDOW_MAX];
  int unsigned         win_fill;
  int unsigned         ring_ptr;
  logic [ACNT_W-1:0]   alert_tally;

  median_word_t expected_words [$];

  int unsigned mismatch_count = 0;
  int unsigned rx_wait        = 0;
  int unsigned rx_hold        = 0;
  bit          tx_burst       = 1'b0;
  bit          rx_burst       = 1'b0;

  // Register value as the block uses it: 0 counts as 1, clamp to the ring.
  function automatic int unsigned window_size();
    if (win_len_reg == '0) return 1;
    if (win_len_reg > WINDOW_MAX) return WINDOW_MAX;
    return 32'(win_len_reg);
  endfunction

  function automatic int unsigned pick_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 7);
  endfunction

  // Clear everything a window_length write clears.
  task automatic clear_window_model();
    foreach (hist_bins[i]) hist_bins[i] = '0;
    win_fill    = 0;
    ring_ptr    = 0;
    alert_tally = '0;
  endtask

  // Advance the model by one accepted sample; flag whether it gives a word.
  task automatic predict_median_word(input logic [SAMPLE_W-1:0] s, output bit produced,
                                     output median_word_t w);
    int unsigned len;
    int unsigned pos;
    int unsigned lo_rank;
    int unsigned hi_rank;
    int unsigned cum;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid_sum;
    int unsigned oldest;
    bit          have_lo;
    bit          have_hi;
    bit          flag;
    len      = window_size();
    pos      = (ring_ptr >= len) ? 0 : ring_ptr;
    produced = 1'b0;
    w        = '0;
    if (win_fill < len) begin
      // Still filling: record the sample, no word out.
      hist_ring[pos] = s;
      hist_bins[s]   = hist_bins[s] + 1'b1;
      win_fill++;
    end else begin
      // Cumulative scan for the lower and upper middle ranks.
      lo_rank = (len + 1) / 2;
      hi_rank = len / 2 + 1;
      cum     = 0;
      lo      = 0;
      hi      = 0;
      have_lo = 1'b0;
      have_hi = 1'b0;
      for (int b = 0; b < NUM_BINS; b++) begin
        cum += 32'(hist_bins[b]);
        if (!have_lo && cum >= lo_rank) begin
          lo      = b;
          have_lo = 1'b1;
        end
        if (!have_hi && cum >= hi_rank) begin
          hi      = b;
          have_hi = 1'b1;
        end
      end
      mid_sum = lo + hi;
      flag    = (s >= mid_sum);
      // Saturate the alert total at all ones.
      if (flag && alert_tally != '1) alert_tally = alert_tally + 1'b1;
      // Replace the oldest sample with the new one.
      oldest = 32'(hist_ring[pos]);
      if (hist_bins[oldest] != '0) hist_bins[oldest] = hist_bins[oldest] - 1'b1;
      hist_bins[s]   = hist_bins[s] + 1'b1;
      hist_ring[pos] = s;
      w.twice_median = mid_sum[TM_W-1:0];
      w.alert        = flag;
      w.alert_count  = alert_tally;
      produced       = 1'b1;
    end
    ring_ptr = (pos + 1 >= len) ? 0 : pos + 1;
  endtask

  // ---------------------------------------------------------------------
  // Sample driver. Call at a falling edge; returns at a falling edge.
  // ---------------------------------------------------------------------
  task automatic push_sample(input logic [SAMPLE_W-1:0] s, input int unsigned gap,
                             input bit use_typed, input median_word_t typed_word);
    bit           produced;
    median_word_t w;
    if (gap > 0) begin
      // Drop valid for the idle gap.
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= s;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    // Word accepted at this edge: predict right away.
    predict_median_word(s, produced, w);
    if (produced) expected_words.insert(expected_words.size(), use_typed ? typed_word : w);
    @(negedge clk);
  endtask

  // Write window_length with the block idle: drain results, let any fill
  // word finish and the clearing pass end, then pulse the write enable.
  task automatic write_window(input logic [CFG_W-1:0] v);
    sample_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wen     <= 1'b0;
    win_len_reg  = v;
    clear_window_model();
  endtask

  // ---------------------------------------------------------------------
  // Result sink: ready changes on the falling edge only. A long hold-off
  // lets the output register back up and stall the input side.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      result_ch.ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait = rx_wait - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk) begin : result_check
    median_word_t got;
    median_word_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.twice_median = result_ch.twice_median;
      got.alert        = result_ch.alert;
      got.alert_count  = result_ch.alert_count;
      if (expected_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("[%0t] unexpected result word: median2=%0d alert=%0d count=%0d",
                   $realtime, got.twice_median, got.alert, got.alert_count);
      end else begin
        want = expected_words.pop_front();
        if (got.twice_median !== want.twice_median || got.alert !== want.alert ||
            got.alert_count !== want.alert_count) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] result mismatch: median2 %0d/%0d alert %0d/%0d count %0d/%0d %s",
                     $realtime, want.twice_median, got.twice_median, want.alert,
                     got.alert, want.alert_count, got.alert_count, "(expected/actual)");
        end
      end
      // Draw the stall before the next result.
      rx_wait = pick_gap(rx_burst);
    end
  end

  // Watchdog: count cycles in which no handshake and no write happen.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || cfg_wen || (sample_ch.valid && sample_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no progress for %0d cycles", $realtime, quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus: directed table, then random phases of window settings.
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int unsigned         phase;
    int unsigned         n_res;
    int unsigned         n_items;
    int unsigned         random_items;
    logic [CFG_W-1:0]    len_val;
    logic [SAMPLE_W-1:0] base;
    logic [SAMPLE_W-1:0] s;
    rst              = 1'b1;
    cfg_wen          = 1'b0;
    cfg_wdata        = '0;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    win_len_reg      = 11'd1;
    foreach (hist_ring[i]) hist_ring[i] = '0;
    clear_window_model();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed table; the first rows use the reset window of 1.
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (directed_rows[r].set_len) write_window(directed_rows[r].len);
      push_sample(directed_rows[r].sample, pick_gap(1'b0), directed_rows[r].typed,
                  directed_rows[r].want);
    end

    // Random phases: mostly short windows, plus a zero length, an oversize
    // value that clamps to the full ring, and some mid-size windows.
    phase        = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (phase == 1)            len_val = 11'd0;
      else if (phase == 2)       len_val = 11'd2047;
      else if (phase % 7 == 3)   len_val = CFG_W'($urandom_range(9, 64));
      else                       len_val = CFG_W'($urandom_range(1, 8));
      write_window(len_val);
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      n_res    = (window_size() == WINDOW_MAX) ? 16 : $urandom_range(20, 60);
      n_items  = window_size() + n_res;
      base     = SAMPLE_W'($urandom_range(0, 240));
      for (int k = 0; k < n_items; k++) begin
        // Hold the receiver off for a long stretch while samples keep coming.
        if (phase == 1 && k == window_size() + HOLD_AFTER) rx_hold = LONG_HOLD;
        // Hold the sender once mid-phase until every result is back.
        if (phase == 4 && k == n_items / 2) begin
          sample_ch.valid <= 1'b0;
          @(negedge clk);
          while (expected_words.size() != 0) @(negedge clk);
        end
        case ($urandom_range(0, 3))
          0:       s = SAMPLE_W'($urandom_range(0, 255));
          1:       s = SAMPLE_W'(base + $urandom_range(0, 15));
          2:       s = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
          default: s = SAMPLE_W'($urandom_range(0, 15));
        endcase
        push_sample(s, pick_gap(tx_burst), 1'b0, '0);
      end
      random_items += n_items;
      phase++;
    end

    // Drain: wait out outstanding words, then one more scan's worth.
    sample_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
